// ===== rtl/core/acceleration_histogram_macros.svh =====
// ----------------------------------------------------------------------------
// acceleration histogram assertion macros
// shared property shapes for the histogram checker, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef ACCELERATION_HISTOGRAM_MACROS_SVH
`define ACCELERATION_HISTOGRAM_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define AH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ah_pkg.sv =====
// ----------------------------------------------------------------------------
// ah_pkg
// types, field widths, command and register codes of the acceleration histogram
// ----------------------------------------------------------------------------
`default_nettype none

package ah_pkg;

  localparam int BINS_DEFAULT        = 256;
  localparam int COUNT_WIDTH_DEFAULT = 24;

  localparam int BIN_WIDTH_W = 12;
  localparam int THRESHOLD_W = 15;
  localparam int SAMPLE_W    = 16;
  localparam int SELECT_W    = 8;
  localparam int OUT_COUNT_W = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RESET = 12'd25;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 15'd4000;
  localparam logic [THRESHOLD_W-1:0] LOWER_MAX       = 15'h7fff;
  localparam logic [31:0]            OUT_COUNT_MAX   = 32'h00ff_ffff;

  localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_THRESHOLD = 1'b1;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // radix-16 restoring divider: 16-bit dividend, 12-bit divisor
  localparam int DIV_DVD_W  = 16;
  localparam int DIV_DSR_W  = BIN_WIDTH_W;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = DIV_DVD_W / DIV_STEPS;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [SAMPLE_W-1:0] sample_mg;
    logic                       sample_valid;
    logic [SELECT_W-1:0]        bin_select;
  } req_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [THRESHOLD_W-1:0] lower_bound;
    logic                   overflow_bin;
    logic [OUT_COUNT_W-1:0] valid_total;
  } rsp_t;

  function automatic logic [OUT_COUNT_W-1:0] cap_out(input logic [31:0] v);
    return (v > OUT_COUNT_MAX) ? OUT_COUNT_MAX[OUT_COUNT_W-1:0] : v[OUT_COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ah_ram.sv =====
// ----------------------------------------------------------------------------
// ah_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ah_divider.sv =====
// ----------------------------------------------------------------------------
// ah_divider
// unsigned restoring divider, four quotient bits per cycle, done pulse at end
// ----------------------------------------------------------------------------
`default_nettype none

module ah_divider
  import ah_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [DIV_DSR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_DVD_W-1:0] quotient
);

  localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DSR_W-1:0] rem;
  logic [DIV_DSR_W-1:0] dsr;

  logic [DIV_DVD_W-1:0] dvd_next;
  logic [DIV_DSR_W-1:0] rem_next;
  logic [DIV_DVD_W-1:0] quotient_next;

  always_comb begin
    logic [DIV_DSR_W:0]   r;
    logic [DIV_DVD_W-1:0] d;
    logic [DIV_DVD_W-1:0] q;
    r = {1'b0, rem};
    d = dvd;
    q = quotient;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[DIV_DSR_W-1:0], d[DIV_DVD_W-1]};
      d = {d[DIV_DVD_W-2:0], 1'b0};
      if (r >= {1'b0, dsr}) begin
        r = r - {1'b0, dsr};
        q = {q[DIV_DVD_W-2:0], 1'b1};
      end else begin
        q = {q[DIV_DVD_W-2:0], 1'b0};
      end
    end
    dvd_next      = d;
    rem_next      = r[DIV_DSR_W-1:0];
    quotient_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        dvd      <= dvd_next;
        rem      <= rem_next;
        quotient <= quotient_next;
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/acceleration_histogram.sv =====
// ----------------------------------------------------------------------------
// acceleration_histogram
// fixed-width histogram of milligravity samples with an open-ended top bin
// ----------------------------------------------------------------------------
// add: a sample in the top bin goes straight to the count update, else the divider finds the bin first
// read: result word registered once the output register is free; no new word is taken before that
// clear: starts the zeroing pass and resets the total; one command word is worked on at a time
// reset and clear zero the count memory one entry a cycle, commands stall
// a register write reruns the divider for the overflow bin index; commands stall until it is done
`default_nettype none

module acceleration_histogram
  import ah_pkg::*;
#(
  parameter int BINS        = BINS_DEFAULT,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req_word,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int PROD_W = SELECT_W + BIN_WIDTH_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BINS - 1);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DIV_LAST,
    S_DIV_BIN,
    S_ACCESS
  } state_t;

  state_t                 state;
  logic                   dirty;
  logic [IDX_W-1:0]       last_bin;
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       addr;
  logic [COUNT_WIDTH-1:0] total;
  logic                   op_read;
  logic                   sel_in_range;
  logic                   sel_is_last;
  logic [THRESHOLD_W-1:0] lower;
  logic [BIN_WIDTH_W-1:0] bin_width;
  logic [THRESHOLD_W-1:0] top_threshold;

  logic                   req_take;
  logic                   cfg_take;
  logic                   rsp_fire;
  logic [BIN_WIDTH_W-1:0] eff_width;
  logic [THRESHOLD_W-1:0] clamp_val;
  logic                   add_top;
  logic [PROD_W-1:0]      lower_prod;
  logic                   div_start;
  logic [DIV_DVD_W-1:0]   div_dividend;
  logic                   div_done;
  logic [DIV_DVD_W-1:0]   div_quotient;
  logic [DIV_DVD_W-1:0]   q_floor;
  logic [IDX_W-1:0]       last_from_div;
  logic [IDX_W-1:0]       bin_from_div;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] total_inc;
  rsp_t                   rsp_load;

  assign req_stall = !((state == S_IDLE) && !dirty);
  assign req_take  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign rsp_fire  = (state == S_ACCESS) && op_read && (!rsp_valid || !rsp_stall);

  assign eff_width = (bin_width == '0) ? BIN_WIDTH_W'(1) : bin_width;
  // negative samples clamp to zero
  assign clamp_val = req_word.sample_mg[SAMPLE_W-1] ? '0 : req_word.sample_mg[THRESHOLD_W-1:0];
  assign add_top   = clamp_val >= top_threshold;

  assign lower_prod = PROD_W'(req_word.bin_select) * PROD_W'(eff_width);

  // overflow bin index: threshold / width, at least 1, at most BINS - 1
  assign q_floor       = (div_quotient == '0) ? DIV_DVD_W'(1) : div_quotient;
  assign last_from_div = (32'(q_floor) > 32'(BINS - 1)) ? IDX_LAST : IDX_W'(q_floor);
  assign bin_from_div  = (32'(div_quotient) >= 32'(last_bin)) ? last_bin - IDX_W'(1)
                                                              : IDX_W'(div_quotient);

  assign div_start    = (state == S_IDLE) && (dirty || (req_take && req_word.cmd == CMD_ADD &&
                                                        req_word.sample_valid && !add_top));
  assign div_dividend = dirty ? DIV_DVD_W'(top_threshold) : DIV_DVD_W'(clamp_val);

  assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
  assign total_inc = (total == '1) ? total : total + COUNT_WIDTH'(1);

  always_comb begin
    rsp_load.bin_count    = sel_in_range ? cap_out(32'(ram_rdata)) : '0;
    rsp_load.lower_bound  = !sel_in_range ? '0 : (sel_is_last ? top_threshold : lower);
    rsp_load.overflow_bin = sel_in_range && sel_is_last;
    rsp_load.valid_total  = cap_out(32'(total));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = count_inc;
    ram_re    = 1'b0;
    ram_raddr = addr;
    case (state)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re    = req_take;
        ram_raddr = (req_word.cmd == CMD_READ) ? IDX_W'(req_word.bin_select) : last_bin;
      end
      S_DIV_BIN: begin
        ram_re    = div_done;
        ram_raddr = bin_from_div;
      end
      S_ACCESS: begin
        ram_we = !op_read;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width     <= BIN_WIDTH_RESET;
      top_threshold <= THRESHOLD_RESET;
    end else if (cfg_take) begin
      case (cfg_index)
        REG_BIN_WIDTH:     bin_width     <= cfg_data[BIN_WIDTH_W-1:0];
        REG_TOP_THRESHOLD: top_threshold <= cfg_data[THRESHOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      ptr       <= '0;
      dirty     <= 1'b1;
      total     <= '0;
      last_bin  <= IDX_LAST;
      op_read   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_take) begin
        dirty <= 1'b1;
      end else if ((state == S_IDLE) && dirty) begin
        dirty <= 1'b0;
      end
      if (rsp_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          ptr <= ptr + IDX_W'(1);
          if (ptr == IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (dirty) begin
            state <= S_DIV_LAST;
          end else if (req_take) begin
            case (req_word.cmd)
              CMD_ADD: begin
                if (req_word.sample_valid) begin
                  op_read <= 1'b0;
                  addr    <= last_bin;
                  state   <= add_top ? S_ACCESS : S_DIV_BIN;
                end
              end
              CMD_READ: begin
                op_read      <= 1'b1;
                addr         <= IDX_W'(req_word.bin_select);
                sel_in_range <= 32'(req_word.bin_select) < 32'(BINS);
                sel_is_last  <= 32'(req_word.bin_select) == 32'(last_bin);
                lower        <= (lower_prod > PROD_W'(LOWER_MAX)) ? LOWER_MAX
                                                                  : lower_prod[THRESHOLD_W-1:0];
                state        <= S_ACCESS;
              end
              CMD_CLEAR: begin
                ptr   <= '0;
                total <= '0;
                state <= S_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV_LAST: begin
          if (div_done) begin
            last_bin <= last_from_div;
            state    <= S_IDLE;
          end
        end
        S_DIV_BIN: begin
          if (div_done) begin
            addr  <= bin_from_div;
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          // count write-back happens here for an add; a read waits for the output register
          if (!op_read) begin
            total <= total_inc;
            state <= S_IDLE;
          end else if (rsp_fire) begin
            rsp_word <= rsp_load;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ah_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_width),
    .done     (div_done),
    .quotient (div_quotient)
  );

  ah_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ah_checker.sv =====
// ----------------------------------------------------------------------------
// ah_checker
// port-level checks on the acceleration histogram, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "acceleration_histogram_macros.svh"

module ah_checker
  import ah_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req_word,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_word
);

  `AH_ASSERT_NEXT(rsp_hold_a, rsp_valid && rsp_stall, rsp_valid, "stalled response word dropped")

  `AH_ASSERT_NEXT(rsp_stable_a, rsp_valid && rsp_stall, $stable(rsp_word), "stalled response word changed")

  // a fresh response word comes only after a read command word has been taken
  `AH_ASSERT_SAME(rsp_from_read_a, $rose(rsp_valid), $past(req_valid && !req_stall && req_word.cmd == CMD_READ, 2), "response word without a read command")

  // no bin can hold more samples than were counted in total
  `AH_ASSERT_SAME(count_le_total_a, rsp_valid, rsp_word.bin_count <= rsp_word.valid_total, "bin count above valid total")

  // clear starts the zeroing pass, so command words stall right after
  `AH_ASSERT_NEXT(clear_stalls_a, req_valid && !req_stall && req_word.cmd == CMD_CLEAR, req_stall, "command word taken during clear")

endmodule

bind acceleration_histogram ah_checker u_ah_checker (.*);

`default_nettype wire
